[rtl/core/ptrt_pkg.sv]
// ptrt_pkg: shared types and constants for the periodic task ready timer
// request modes, controller states, control and status bundles
// no dependencies
package ptrt_pkg;

  // field widths of the request and result ports
  localparam int MODE_W    = 3;
  localparam int PERIOD_W  = 24;
  localparam int SLOT_W    = 8;
  localparam int TASK_ID_W = 3;
  localparam int USED_W    = 4;

  // result kinds
  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_RUN = 1'b1;

  // request modes
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK    = 3'd0,
    MODE_ADD     = 3'd1,
    MODE_ENABLE  = 3'd2,
    MODE_DISABLE = 3'd3,
    MODE_RUN     = 3'd4
  } mode_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_RD,
    ST_TICK_WR,
    ST_EN_RD,
    ST_EN_WR,
    ST_RUN
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic idx_zero;  // scan index to slot 0
    logic idx_slot;  // scan index to the requested handle
    logic idx_inc;   // step scan index
    logic add;       // add request in this cycle
    logic dis;       // disable the requested handle
    logic tick_wr;   // write back one countdown of a tick
    logic en_wr;     // reload countdown and activate for enable
    logic emit;      // report the current slot of a run
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic cnt_zero;    // no slot in use
    logic slot_ok;     // requested handle is in use
    logic idx_last;    // scan index on the last used slot
    logic cur_pend;    // current slot is pending
    logic more_above;  // some slot past the current one is pending
  } ctrl_sts_t;

endpackage

[rtl/core/ptrt_ctrl.sv]
// ptrt_ctrl: sequencer of the periodic task ready timer
// decodes a request, walks the slots for tick, enable and run
// depends on ptrt_pkg
module ptrt_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [ptrt_pkg::MODE_W-1:0]       in_mode,
  input  ptrt_pkg::ctrl_sts_t               sts,
  output ptrt_pkg::ctrl_cmd_t               cmd,
  output logic                              busy
);
  import ptrt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_mode)
            MODE_TICK: begin
              if (!sts.cnt_zero) begin
                cmd.idx_zero = 1'b1;
                state_nxt    = ST_TICK_RD;
              end
            end
            MODE_ADD: begin
              cmd.add = 1'b1;
            end
            MODE_ENABLE: begin
              if (sts.slot_ok) begin
                cmd.idx_slot = 1'b1;
                state_nxt    = ST_EN_RD;
              end
            end
            MODE_DISABLE: begin
              cmd.dis = sts.slot_ok;
            end
            MODE_RUN: begin
              if (!sts.cnt_zero) begin
                cmd.idx_zero = 1'b1;
                state_nxt    = ST_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      // tables read at the scan index
      ST_TICK_RD: begin
        state_nxt = ST_TICK_WR;
      end
      // countdown written back, move to next slot or back to idle after the last
      ST_TICK_WR: begin
        cmd.tick_wr = 1'b1;
        if (sts.idx_last) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_TICK_RD;
        end
      end
      ST_EN_RD: begin
        state_nxt = ST_EN_WR;
      end
      ST_EN_WR: begin
        cmd.en_wr = 1'b1;
        state_nxt = ST_IDLE;
      end
      // one slot per cycle, stop once nothing further is pending
      ST_RUN: begin
        cmd.emit = sts.cur_pend;
        if (sts.idx_last || !sts.more_above) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

[rtl/core/ptrt_dp.sv]
// ptrt_dp: datapath of the periodic task ready timer
// interval and countdown memories, flag vectors, slot count, result register
// depends on ptrt_pkg
module ptrt_dp #(
  parameter int NUM_TASKS   = 8,
  parameter int PERIOD_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [ptrt_pkg::PERIOD_W-1:0]     in_period,
  input  logic [ptrt_pkg::SLOT_W-1:0]       in_slot,
  input  ptrt_pkg::ctrl_cmd_t               cmd,
  output ptrt_pkg::ctrl_sts_t               sts,
  output logic                              out_valid,
  output logic                              out_kind,
  output logic [ptrt_pkg::TASK_ID_W-1:0]    out_task_id,
  output logic                              out_add_ok,
  output logic                              out_last,
  output logic [ptrt_pkg::USED_W-1:0]       out_used_slots
);
  import ptrt_pkg::*;

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CNT_W = $clog2(NUM_TASKS + 1);

  // tables, filled in slot order so only used slots are ever read
  logic [PERIOD_BITS-1:0] iv_mem [NUM_TASKS];
  logic [PERIOD_BITS-1:0] cd_mem [NUM_TASKS];
  logic [PERIOD_BITS-1:0] iv_rd_r;
  logic [PERIOD_BITS-1:0] cd_rd_r;

  logic [CNT_W-1:0]     count_r,   count_nxt;
  logic [IDX_W-1:0]     idx_r,     idx_nxt;
  logic [NUM_TASKS-1:0] active_r,  active_nxt;
  logic [NUM_TASKS-1:0] pending_r, pending_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 out_kind_r;
  logic [TASK_ID_W-1:0] out_task_id_r;
  logic                 out_add_ok_r;
  logic                 out_last_r;
  logic [USED_W-1:0]    out_used_slots_r;

  logic [PERIOD_BITS-1:0] period_w;
  logic                   add_ok;
  logic                   add_do;
  logic [IDX_W-1:0]       add_idx;
  logic [NUM_TASKS-1:0]   pend_shift;
  logic [PERIOD_BITS-1:0] cd_dec;
  logic                   fire;
  logic                   tick_act;
  logic                   cd_we;
  logic [IDX_W-1:0]       cd_waddr;
  logic [PERIOD_BITS-1:0] cd_wdata;

  // request decode and status
  always_comb begin
    period_w       = PERIOD_BITS'(in_period);
    add_ok         = (period_w != '0) && (count_r < CNT_W'(NUM_TASKS));
    add_do         = cmd.add && add_ok;
    add_idx        = count_r[IDX_W-1:0];
    pend_shift     = pending_r >> idx_r;
    sts.cnt_zero   = (count_r == '0);
    sts.slot_ok    = (in_slot < SLOT_W'(count_r));
    sts.idx_last   = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
    sts.cur_pend   = pend_shift[0];
    sts.more_above = |(pend_shift >> 1);
  end

  // countdown step: hold at zero, fire and reload when zero is reached
  always_comb begin
    cd_dec   = (cd_rd_r != '0) ? (cd_rd_r - PERIOD_BITS'(1)) : '0;
    fire     = (cd_dec == '0);
    tick_act = cmd.tick_wr && active_r[idx_r];
    cd_we    = add_do || tick_act || cmd.en_wr;
    cd_waddr = cmd.add ? add_idx : idx_r;
    if (cmd.add) begin
      cd_wdata = period_w;
    end else if (cmd.en_wr || fire) begin
      cd_wdata = iv_rd_r;
    end else begin
      cd_wdata = cd_dec;
    end
  end

  // next values of control state
  always_comb begin
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    active_nxt  = active_r;
    pending_nxt = pending_r;
    out_valid_nxt = cmd.add || cmd.emit;
    if (add_do) begin
      count_nxt            = count_r + CNT_W'(1);
      active_nxt[add_idx]  = 1'b0;
      pending_nxt[add_idx] = 1'b0;
    end
    if (cmd.dis) begin
      active_nxt[in_slot[IDX_W-1:0]] = 1'b0;
    end
    if (cmd.en_wr) begin
      active_nxt[idx_r] = 1'b1;
    end
    if (tick_act && fire) begin
      pending_nxt[idx_r] = 1'b1;
    end
    if (cmd.emit) begin
      pending_nxt[idx_r] = 1'b0;
    end
    priority if (cmd.idx_zero) begin
      idx_nxt = '0;
    end else if (cmd.idx_slot) begin
      idx_nxt = in_slot[IDX_W-1:0];
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + IDX_W'(1);
    end else begin
      idx_nxt = idx_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      active_r    <= '0;
      pending_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      active_r    <= active_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // table memories, registered read at the scan index
  always_ff @(posedge clk) begin
    if (add_do) begin
      iv_mem[add_idx] <= period_w;
    end
    if (cd_we) begin
      cd_mem[cd_waddr] <= cd_wdata;
    end
    iv_rd_r <= iv_mem[idx_r];
    cd_rd_r <= cd_mem[idx_r];
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.add) begin
      out_kind_r       <= KIND_ADD;
      out_task_id_r    <= add_ok ? TASK_ID_W'(count_r) : '0;
      out_add_ok_r     <= add_ok;
      out_last_r       <= 1'b1;
      out_used_slots_r <= USED_W'(count_nxt);
    end else if (cmd.emit) begin
      out_kind_r       <= KIND_RUN;
      out_task_id_r    <= TASK_ID_W'(idx_r);
      out_add_ok_r     <= 1'b0;
      out_last_r       <= !sts.more_above;
      out_used_slots_r <= USED_W'(count_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_task_id    = out_task_id_r;
  assign out_add_ok     = out_add_ok_r;
  assign out_last       = out_last_r;
  assign out_used_slots = out_used_slots_r;

endmodule

[rtl/core/periodic_task_ready_timer.sv]
// periodic_task_ready_timer: top level of the periodic task ready timer
// joins the sequencer (ptrt_ctrl) and the datapath (ptrt_dp)
// depends on ptrt_pkg, ptrt_ctrl, ptrt_dp
//
//   channel   ports                                  handshake
//   request   in_mode, in_period, in_slot            start high, busy low
//   result    out_kind, out_task_id, out_add_ok,     out_valid, one cycle
//             out_last, out_used_slots
//
// add, disable and unused modes are handled in the request cycle; an add reply shows the next cycle
// enable steps through ST_EN_RD and ST_EN_WR: interval read, then countdown reload
// tick walks the N used slots: each slot is a memory read then
// a write back through the single countdown port
// run checks up to N slots, one slot checked per cycle, at most one report each
// reset is synchronous, active low; the tables need no clearing since only used
// slots are read; results cannot be held off by the receiver
module periodic_task_ready_timer #(
  parameter int NUM_TASKS   = 8,
  parameter int PERIOD_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [ptrt_pkg::MODE_W-1:0]       in_mode,
  input  logic [ptrt_pkg::PERIOD_W-1:0]     in_period,
  input  logic [ptrt_pkg::SLOT_W-1:0]       in_slot,
  output logic                              out_valid,
  output logic                              out_kind,
  output logic [ptrt_pkg::TASK_ID_W-1:0]    out_task_id,
  output logic                              out_add_ok,
  output logic                              out_last,
  output logic [ptrt_pkg::USED_W-1:0]       out_used_slots
);
  import ptrt_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer
  ptrt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  // tables, flags and result register
  ptrt_dp #(
    .NUM_TASKS   (NUM_TASKS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_period      (in_period),
    .in_slot        (in_slot),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_task_id    (out_task_id),
    .out_add_ok     (out_add_ok),
    .out_last       (out_last),
    .out_used_slots (out_used_slots)
  );

`ifndef NO_ASSERTIONS
  // an accepted add request is answered in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == MODE_ADD) |=> (out_valid && out_kind == KIND_ADD))
    else $error("add request not answered");

  // add replies always close their request
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_ADD) |-> out_last)
    else $error("add reply without last");

  // run reports come from the slot scan only
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_RUN) |-> ($past(busy) && !out_add_ok))
    else $error("run report outside of a scan");

  // each report command lands on the result port
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (out_valid && out_kind == KIND_RUN))
    else $error("ready report lost");
`endif

endmodule
